/* rtl/mtt_pkg.sv */
package mtt_pkg;

  localparam int TEMP_W = 9;
  localparam int FREQ_W = 22;
  localparam int LVL_W  = 2;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [TEMP_W-1:0] SENSOR1_SANE_MAX = 9'd150;

  localparam logic [TEMP_W-1:0] RST_SHUTDOWN_LEVEL = 9'd80;
  localparam logic [TEMP_W-1:0] RST_MAX_TRIP       = 9'd75;
  localparam logic [TEMP_W-1:0] RST_MAX_CLEAR      = 9'd71;
  localparam logic [TEMP_W-1:0] RST_MID_TRIP       = 9'd72;
  localparam logic [TEMP_W-1:0] RST_MID_CLEAR      = 9'd67;
  localparam logic [TEMP_W-1:0] RST_LOW_TRIP       = 9'd70;
  localparam logic [TEMP_W-1:0] RST_LOW_CLEAR      = 9'd64;
  localparam logic [FREQ_W-1:0] RST_FALLBACK       = 22'd1512000;

  localparam logic [LVL_W-1:0] LVL_NONE = 2'd0;
  localparam logic [LVL_W-1:0] LVL_LOW  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_MID  = 2'd2;
  localparam logic [LVL_W-1:0] LVL_MAX  = 2'd3;

  typedef enum logic [2:0] {
    REG_SHUTDOWN_LEVEL   = 3'd0,
    REG_MAX_TRIP         = 3'd1,
    REG_MAX_CLEAR        = 3'd2,
    REG_MID_TRIP         = 3'd3,
    REG_MID_CLEAR        = 3'd4,
    REG_LOW_TRIP         = 3'd5,
    REG_LOW_CLEAR        = 3'd6,
    REG_FALLBACK_CEILING = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [TEMP_W-1:0] shutdown_level;
    logic [TEMP_W-1:0] max_trip;
    logic [TEMP_W-1:0] max_clear;
    logic [TEMP_W-1:0] mid_trip;
    logic [TEMP_W-1:0] mid_clear;
    logic [TEMP_W-1:0] low_trip;
    logic [TEMP_W-1:0] low_clear;
    logic [FREQ_W-1:0] fallback_ceiling;
  } cfg_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temp_a;
    logic [TEMP_W-1:0] temp_b;
    logic              fail_a;
    logic              fail_b;
    logic              display_off;
    logic [FREQ_W-1:0] present_ceiling;
  } item_t;

  typedef struct packed {
    logic              apply_limit;
    logic [LVL_W-1:0]  limit_code;
    logic [FREQ_W-1:0] restore_freq;
    logic              used_fallback;
    logic              wake_cores;
    logic              power_off;
    logic [LVL_W-1:0]  new_level;
    logic              chosen_sensor;
    logic [TEMP_W-1:0] used_temp;
    logic              skipped;
  } result_t;

endpackage

/* rtl/mtt_regs.sv */
module mtt_regs
  import mtt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_SHUTDOWN_LEVEL:   cfg_nxt.shutdown_level   = pwdata[TEMP_W-1:0];
        REG_MAX_TRIP:         cfg_nxt.max_trip         = pwdata[TEMP_W-1:0];
        REG_MAX_CLEAR:        cfg_nxt.max_clear        = pwdata[TEMP_W-1:0];
        REG_MID_TRIP:         cfg_nxt.mid_trip         = pwdata[TEMP_W-1:0];
        REG_MID_CLEAR:        cfg_nxt.mid_clear        = pwdata[TEMP_W-1:0];
        REG_LOW_TRIP:         cfg_nxt.low_trip         = pwdata[TEMP_W-1:0];
        REG_LOW_CLEAR:        cfg_nxt.low_clear        = pwdata[TEMP_W-1:0];
        REG_FALLBACK_CEILING: cfg_nxt.fallback_ceiling = pwdata[FREQ_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SHUTDOWN_LEVEL:   prdata = DATA_W'(cfg_r.shutdown_level);
      REG_MAX_TRIP:         prdata = DATA_W'(cfg_r.max_trip);
      REG_MAX_CLEAR:        prdata = DATA_W'(cfg_r.max_clear);
      REG_MID_TRIP:         prdata = DATA_W'(cfg_r.mid_trip);
      REG_MID_CLEAR:        prdata = DATA_W'(cfg_r.mid_clear);
      REG_LOW_TRIP:         prdata = DATA_W'(cfg_r.low_trip);
      REG_LOW_CLEAR:        prdata = DATA_W'(cfg_r.low_clear);
      REG_FALLBACK_CEILING: prdata = DATA_W'(cfg_r.fallback_ceiling);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shutdown_level   <= RST_SHUTDOWN_LEVEL;
      cfg_r.max_trip         <= RST_MAX_TRIP;
      cfg_r.max_clear        <= RST_MAX_CLEAR;
      cfg_r.mid_trip         <= RST_MID_TRIP;
      cfg_r.mid_clear        <= RST_MID_CLEAR;
      cfg_r.low_trip         <= RST_LOW_TRIP;
      cfg_r.low_clear        <= RST_LOW_CLEAR;
      cfg_r.fallback_ceiling <= RST_FALLBACK;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/mtt_core.sv */
module mtt_core
  import mtt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  cfg_t    cfg,
  input  item_t   item,
  output result_t res
);

  logic [LVL_W-1:0]  level_r, level_nxt;
  logic [FREQ_W-1:0] saved_r, saved_nxt;

  logic [TEMP_W-1:0] ta, tb, temp;
  logic              a_only, a_gt, skip, poff;
  logic [LVL_W-1:0]  lvl_in, lvl_out;

  always_comb begin
    ta     = item.fail_a ? '0 : item.temp_a;
    tb     = item.fail_b ? '0 : item.temp_b;
    skip   = item.fail_a & item.fail_b;
    a_only = item.display_off | (tb > SENSOR1_SANE_MAX);
    a_gt   = ta > tb;
    temp   = (a_only | a_gt) ? ta : tb;
    poff   = temp >= cfg.shutdown_level;
    lvl_in = poff ? LVL_MAX : level_r;
  end

  always_comb begin
    res               = '0;
    res.power_off     = poff;
    res.chosen_sensor = ~(a_only | a_gt);
    res.used_temp     = temp;
    lvl_out           = lvl_in;
    priority if (temp >= cfg.low_trip && temp < cfg.mid_trip && lvl_in == LVL_NONE) begin
      res.apply_limit = 1'b1;
      res.limit_code  = LVL_LOW;
      lvl_out         = LVL_LOW;
    end else if (temp < cfg.low_clear && lvl_in != LVL_NONE) begin
      res.apply_limit = 1'b1;
      res.limit_code  = LVL_NONE;
      res.wake_cores  = 1'b1;
      lvl_out         = LVL_NONE;
      if (saved_r != '0) begin
        res.restore_freq = saved_r;
      end else begin
        res.restore_freq  = cfg.fallback_ceiling;
        res.used_fallback = 1'b1;
      end
    end else if (temp >= cfg.mid_trip && temp < cfg.max_trip && lvl_in < LVL_MID) begin
      res.apply_limit = 1'b1;
      res.limit_code  = LVL_MID;
      lvl_out         = LVL_MID;
    end else if (temp < cfg.mid_clear && lvl_in > LVL_LOW) begin
      res.apply_limit = 1'b1;
      res.limit_code  = LVL_LOW;
      lvl_out         = LVL_LOW;
    end else if (temp >= cfg.max_trip) begin
      res.apply_limit = 1'b1;
      res.limit_code  = LVL_MAX;
      lvl_out         = LVL_MAX;
    end else if (temp < cfg.max_clear && lvl_in == LVL_MAX) begin
      res.apply_limit = 1'b1;
      res.limit_code  = LVL_MID;
      lvl_out         = LVL_MID;
    end
    res.new_level = lvl_out;
    if (skip) begin
      res           = '0;
      res.new_level = level_r;
      res.skipped   = 1'b1;
    end
  end

  always_comb begin
    level_nxt = level_r;
    saved_nxt = saved_r;
    if (en && !skip) begin
      level_nxt = lvl_out;
      if (lvl_in == LVL_NONE) begin
        saved_nxt = item.present_ceiling;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= LVL_NONE;
      saved_r <= '0;
    end else begin
      level_r <= level_nxt;
      saved_r <= saved_nxt;
    end
  end

endmodule

/* rtl/multilevel_thermal_throttle_unit.sv */
// Three-level thermal throttle with hysteresis.
// Input channel (in_valid / in_stall): one sample beat per tick while in_stall
// is low, with two sensor temperatures, read-fail flags, screen-blank flag and present
// frequency ceiling. Output channel (out_valid / out_stall): exactly one
// result beat per sample, in order.
// Thresholds and fallback ceiling sit on the APB port at byte address
// 4*index; write them only while no beat is in flight.
// An accepted beat waits in the input register; its result then moves to the result register, which drives out_valid.
// Throughput: one beat per cycle while out_stall is low; the decision reads the
// level and saved ceiling left by the previous beat through one comparator/priority
// stage between the input register and the result register.
// Reset (rst_n low, synchronous): pipeline empty, level 0, saved ceiling 0,
// registers at their defaults.
// Stall: a stalled result holds; the input register keeps taking one more
// beat, then in_stall rises until the result drains.
module multilevel_thermal_throttle_unit
  import mtt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TEMP_W-1:0] in_temp_a,
  input  logic [TEMP_W-1:0] in_temp_b,
  input  logic              in_fail_a,
  input  logic              in_fail_b,
  input  logic              in_display_off,
  input  logic [FREQ_W-1:0] in_present_ceiling,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_apply_limit,
  output logic [LVL_W-1:0]  out_limit_code,
  output logic [FREQ_W-1:0] out_restore_freq,
  output logic              out_used_fallback,
  output logic              out_wake_cores,
  output logic              out_power_off,
  output logic [LVL_W-1:0]  out_new_level,
  output logic              out_chosen_sensor,
  output logic [TEMP_W-1:0] out_used_temp,
  output logic              out_skipped
);

  cfg_t    cfg;
  item_t   s1_item_r;
  logic    s1_valid_r, s1_valid_nxt;
  logic    out_valid_r, out_valid_nxt;
  result_t res;
  result_t res_r;
  logic    advance, accept;

  mtt_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mtt_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .cfg   (cfg),
    .item  (s1_item_r),
    .res   (res)
  );

  assign advance       = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall      = s1_valid_r & ~advance;
  assign accept        = in_valid & ~in_stall;
  assign s1_valid_nxt  = accept | (s1_valid_r & ~advance);
  assign out_valid_nxt = advance | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r.temp_a          <= in_temp_a;
      s1_item_r.temp_b          <= in_temp_b;
      s1_item_r.fail_a          <= in_fail_a;
      s1_item_r.fail_b          <= in_fail_b;
      s1_item_r.display_off     <= in_display_off;
      s1_item_r.present_ceiling <= in_present_ceiling;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_apply_limit   = res_r.apply_limit;
  assign out_limit_code    = res_r.limit_code;
  assign out_restore_freq  = res_r.restore_freq;
  assign out_used_fallback = res_r.used_fallback;
  assign out_wake_cores    = res_r.wake_cores;
  assign out_power_off     = res_r.power_off;
  assign out_new_level     = res_r.new_level;
  assign out_chosen_sensor = res_r.chosen_sensor;
  assign out_used_temp     = res_r.used_temp;
  assign out_skipped       = res_r.skipped;

endmodule

/* sim/mtt_checker.sv */
`timescale 1ns / 100ps

module mtt_checker
  import mtt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              in_valid,
  input  logic              in_stall,
  input  item_t             in_beat,
  input  logic              out_valid,
  input  logic              out_stall,
  input  result_t           out_beat,
  output int                n_errors,
  output int                n_pending
);

  cfg_t              thr;
  logic [LVL_W-1:0]  cur_level;
  logic [FREQ_W-1:0] kept_ceiling;
  result_t           due_q[$];
  result_t           want;

  function automatic result_t throttle_decide(input item_t s);
    result_t           r;
    logic [TEMP_W-1:0] ta;
    logic [TEMP_W-1:0] tb;
    logic [TEMP_W-1:0] t;
    logic [LVL_W-1:0]  lv;
    r = '0;
    if (s.fail_a && s.fail_b) begin
      r.new_level = cur_level;
      r.skipped   = 1'b1;
      return r;
    end
    ta = s.fail_a ? '0 : s.temp_a;
    tb = s.fail_b ? '0 : s.temp_b;
    if (s.display_off || tb > SENSOR1_SANE_MAX) begin
      t = ta;
      r.chosen_sensor = 1'b0;
    end else if (ta > tb) begin
      t = ta;
      r.chosen_sensor = 1'b0;
    end else begin
      t = tb;
      r.chosen_sensor = 1'b1;
    end
    if (t >= thr.shutdown_level) begin
      r.power_off = 1'b1;
      cur_level   = LVL_MAX;
    end
    lv = cur_level;
    if (lv == LVL_NONE) kept_ceiling = s.present_ceiling;
    if (t >= thr.low_trip && t < thr.mid_trip && lv < LVL_LOW) begin
      r.apply_limit = 1'b1;
      r.limit_code  = LVL_LOW;
      lv            = LVL_LOW;
    end else if (t < thr.low_clear && lv > LVL_NONE) begin
      r.apply_limit = 1'b1;
      r.limit_code  = LVL_NONE;
      r.wake_cores  = 1'b1;
      lv            = LVL_NONE;
      if (kept_ceiling != '0) begin
        r.restore_freq = kept_ceiling;
      end else begin
        r.restore_freq  = thr.fallback_ceiling;
        r.used_fallback = 1'b1;
      end
    end else if (t >= thr.mid_trip && t < thr.max_trip && lv < LVL_MID) begin
      r.apply_limit = 1'b1;
      r.limit_code  = LVL_MID;
      lv            = LVL_MID;
    end else if (t < thr.mid_clear && lv > LVL_LOW) begin
      r.apply_limit = 1'b1;
      r.limit_code  = LVL_LOW;
      lv            = LVL_LOW;
    end else if (t >= thr.max_trip) begin
      r.apply_limit = 1'b1;
      r.limit_code  = LVL_MAX;
      lv            = LVL_MAX;
    end else if (t < thr.max_clear && lv > LVL_MID) begin
      r.apply_limit = 1'b1;
      r.limit_code  = LVL_MID;
      lv            = LVL_MID;
    end
    cur_level   = lv;
    r.new_level = lv;
    r.used_temp = t;
    return r;
  endfunction

  task automatic flag(input string what, input logic [FREQ_W-1:0] exp_v,
                      input logic [FREQ_W-1:0] got_v);
    if (exp_v !== got_v) begin
      if (n_errors < 10)
        $display("%0t: %s mismatch, expected %0d got %0d", $time, what, exp_v, got_v);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      thr.shutdown_level   = RST_SHUTDOWN_LEVEL;
      thr.max_trip         = RST_MAX_TRIP;
      thr.max_clear        = RST_MAX_CLEAR;
      thr.mid_trip         = RST_MID_TRIP;
      thr.mid_clear        = RST_MID_CLEAR;
      thr.low_trip         = RST_LOW_TRIP;
      thr.low_clear        = RST_LOW_CLEAR;
      thr.fallback_ceiling = RST_FALLBACK;
      cur_level            = LVL_NONE;
      kept_ceiling         = '0;
      due_q.delete();
      n_errors             = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          if (n_errors < 10) $display("%0t: result beat with nothing expected", $time);
          n_errors++;
        end else begin
          want = due_q.pop_front();
          flag("apply_limit",   FREQ_W'(want.apply_limit),   FREQ_W'(out_beat.apply_limit));
          flag("limit_code",    FREQ_W'(want.limit_code),    FREQ_W'(out_beat.limit_code));
          flag("restore_freq",  want.restore_freq,           out_beat.restore_freq);
          flag("used_fallback", FREQ_W'(want.used_fallback), FREQ_W'(out_beat.used_fallback));
          flag("wake_cores",    FREQ_W'(want.wake_cores),    FREQ_W'(out_beat.wake_cores));
          flag("power_off",     FREQ_W'(want.power_off),     FREQ_W'(out_beat.power_off));
          flag("new_level",     FREQ_W'(want.new_level),     FREQ_W'(out_beat.new_level));
          flag("chosen_sensor", FREQ_W'(want.chosen_sensor), FREQ_W'(out_beat.chosen_sensor));
          flag("used_temp",     FREQ_W'(want.used_temp),     FREQ_W'(out_beat.used_temp));
          flag("skipped",       FREQ_W'(want.skipped),       FREQ_W'(out_beat.skipped));
        end
      end
      if (in_valid && !in_stall) due_q.push_back(throttle_decide(in_beat));
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_SHUTDOWN_LEVEL:   thr.shutdown_level   = pwdata[TEMP_W-1:0];
          REG_MAX_TRIP:         thr.max_trip         = pwdata[TEMP_W-1:0];
          REG_MAX_CLEAR:        thr.max_clear        = pwdata[TEMP_W-1:0];
          REG_MID_TRIP:         thr.mid_trip         = pwdata[TEMP_W-1:0];
          REG_MID_CLEAR:        thr.mid_clear        = pwdata[TEMP_W-1:0];
          REG_LOW_TRIP:         thr.low_trip         = pwdata[TEMP_W-1:0];
          REG_LOW_CLEAR:        thr.low_clear        = pwdata[TEMP_W-1:0];
          REG_FALLBACK_CEILING: thr.fallback_ceiling = pwdata[FREQ_W-1:0];
          default: ;
        endcase
      end
    end
    n_pending = due_q.size();
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import mtt_pkg::*;

  localparam int LONG_HOLD       = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int BEATS_PER_PHASE = 325;
  localparam int N_PHASES        = 6;
  localparam int TAIL_CYCLES     = 8;
  localparam int TEMP_TOP        = (1 << TEMP_W) - 1;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic              in_valid, in_stall, out_valid, out_stall;
  item_t             beat;
  result_t           res;
  logic              out_apply_limit, out_used_fallback, out_wake_cores, out_power_off;
  logic              out_chosen_sensor, out_skipped;
  logic [LVL_W-1:0]  out_limit_code, out_new_level;
  logic [FREQ_W-1:0] out_restore_freq;
  logic [TEMP_W-1:0] out_used_temp;
  cfg_t              cfg_plan;
  int                n_errors, n_pending;
  int                walk_temp, burst_left, hold_req, hold_done, idle_cycles;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  multilevel_thermal_throttle_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_temp_a          (beat.temp_a),
    .in_temp_b          (beat.temp_b),
    .in_fail_a          (beat.fail_a),
    .in_fail_b          (beat.fail_b),
    .in_display_off     (beat.display_off),
    .in_present_ceiling (beat.present_ceiling),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_apply_limit    (out_apply_limit),
    .out_limit_code     (out_limit_code),
    .out_restore_freq   (out_restore_freq),
    .out_used_fallback  (out_used_fallback),
    .out_wake_cores     (out_wake_cores),
    .out_power_off      (out_power_off),
    .out_new_level      (out_new_level),
    .out_chosen_sensor  (out_chosen_sensor),
    .out_used_temp      (out_used_temp),
    .out_skipped        (out_skipped)
  );

  always_comb begin
    res.apply_limit   = out_apply_limit;
    res.limit_code    = out_limit_code;
    res.restore_freq  = out_restore_freq;
    res.used_fallback = out_used_fallback;
    res.wake_cores    = out_wake_cores;
    res.power_off     = out_power_off;
    res.new_level     = out_new_level;
    res.chosen_sensor = out_chosen_sensor;
    res.used_temp     = out_used_temp;
    res.skipped       = out_skipped;
  end

  mtt_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (res),
    .n_errors  (n_errors),
    .n_pending (n_pending)
  );

  task automatic pause(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send(input item_t it);
    @(negedge clk);
    beat     <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_fields(input logic [TEMP_W-1:0] ta, input logic [TEMP_W-1:0] tb,
                             input logic fa, input logic fb, input logic off,
                             input logic [FREQ_W-1:0] ceil);
    item_t it;
    it.temp_a          = ta;
    it.temp_b          = tb;
    it.fail_a          = fa;
    it.fail_b          = fb;
    it.display_off     = off;
    it.present_ceiling = ceil;
    send(it);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
  endtask

  task automatic apb_write(input reg_idx_t r, input logic [DATA_W-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_cfg(input cfg_t c);
    cfg_plan = c;
    apb_write(REG_SHUTDOWN_LEVEL,   DATA_W'(c.shutdown_level));
    apb_write(REG_MAX_TRIP,         DATA_W'(c.max_trip));
    apb_write(REG_MAX_CLEAR,        DATA_W'(c.max_clear));
    apb_write(REG_MID_TRIP,         DATA_W'(c.mid_trip));
    apb_write(REG_MID_CLEAR,        DATA_W'(c.mid_clear));
    apb_write(REG_LOW_TRIP,         DATA_W'(c.low_trip));
    apb_write(REG_LOW_CLEAR,        DATA_W'(c.low_clear));
    apb_write(REG_FALLBACK_CEILING, DATA_W'(c.fallback_ceiling));
  endtask

  function automatic int clamp_temp(input int v);
    return (v < 0) ? 0 : ((v > TEMP_TOP) ? TEMP_TOP : v);
  endfunction

  function automatic int step_up(input int v);
    return v + int'($urandom_range(1, 5));
  endfunction

  // 0: defaults, 1: all zero, 2: all ones, 4: unordered, 5: ordered random with zero fallback, else ordered random
  function automatic cfg_t phase_cfg(input int k);
    cfg_t c;
    int   b;
    c = '1;
    if (k == 0) begin
      c.shutdown_level   = RST_SHUTDOWN_LEVEL;
      c.max_trip         = RST_MAX_TRIP;
      c.max_clear        = RST_MAX_CLEAR;
      c.mid_trip         = RST_MID_TRIP;
      c.mid_clear        = RST_MID_CLEAR;
      c.low_trip         = RST_LOW_TRIP;
      c.low_clear        = RST_LOW_CLEAR;
      c.fallback_ceiling = RST_FALLBACK;
    end else if (k == 1) begin
      c = '0;
    end else if (k == 4) begin
      c.shutdown_level   = TEMP_W'($urandom);
      c.max_trip         = TEMP_W'($urandom);
      c.max_clear        = TEMP_W'($urandom);
      c.mid_trip         = TEMP_W'($urandom);
      c.mid_clear        = TEMP_W'($urandom);
      c.low_trip         = TEMP_W'($urandom);
      c.low_clear        = TEMP_W'($urandom);
      c.fallback_ceiling = FREQ_W'($urandom);
    end else if (k != 2) begin
      b = $urandom_range(0, 440);
      c.low_clear        = TEMP_W'(b);
      b = step_up(b);
      c.mid_clear        = TEMP_W'(b);
      b = step_up(b);
      c.low_trip         = TEMP_W'(b);
      b = step_up(b);
      c.max_clear        = TEMP_W'(b);
      b = step_up(b);
      c.mid_trip         = TEMP_W'(b);
      b = step_up(b);
      c.max_trip         = TEMP_W'(b);
      b = step_up(b);
      c.shutdown_level   = TEMP_W'(b);
      c.fallback_ceiling = (k == 5) ? '0 : FREQ_W'($urandom);
    end
    return c;
  endfunction

  // temperature mostly walks so the hysteresis bands get crossed both ways
  function automatic item_t rand_item();
    item_t it;
    int    marks [7];
    int    t, other, pick;
    marks = '{int'(cfg_plan.shutdown_level), int'(cfg_plan.max_trip),
              int'(cfg_plan.max_clear), int'(cfg_plan.mid_trip), int'(cfg_plan.mid_clear),
              int'(cfg_plan.low_trip), int'(cfg_plan.low_clear)};
    pick = $urandom_range(0, 9);
    if (pick == 0)
      t = $urandom_range(0, TEMP_TOP);
    else if (pick < 3)
      t = clamp_temp(marks[3'($urandom_range(0, 6))] + int'($urandom_range(0, 4)) - 2);
    else
      t = clamp_temp(walk_temp + int'($urandom_range(0, 8)) - 4);
    walk_temp = t;
    if ($urandom_range(0, 9) < 3)
      other = $urandom_range(0, TEMP_TOP);
    else
      other = clamp_temp(t + int'($urandom_range(0, 6)) - 3);
    if ($urandom_range(0, 1) == 0) begin
      it.temp_a = TEMP_W'(t);
      it.temp_b = TEMP_W'(other);
    end else begin
      it.temp_a = TEMP_W'(other);
      it.temp_b = TEMP_W'(t);
    end
    it.fail_a      = ($urandom_range(0, 11) == 0);
    it.fail_b      = ($urandom_range(0, 11) == 0);
    it.display_off = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 7);
    if (pick == 0)
      it.present_ceiling = '0;
    else if (pick == 1)
      it.present_ceiling = '1;
    else
      it.present_ceiling = FREQ_W'($urandom);
    return it;
  endfunction

  // receiver: random stall duty per stretch, long hold-off on request
  initial begin
    int n, duty;
    out_stall = 1'b0;
    hold_done = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_done != hold_req) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_done++;
      end else begin
        n    = $urandom_range(1, 40);
        duty = $urandom_range(0, 4) * 25;
        repeat (n) begin
          @(negedge clk);
          out_stall <= ($urandom_range(0, 99) < duty);
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int k, i;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    beat       = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    hold_req   = 0;
    walk_temp  = 70;
    burst_left = 0;
    cfg_plan   = phase_cfg(0);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_fields(9'd511, 9'd511, 1'b1, 1'b1, 1'b0, 22'd0);
    send_fields(9'd0,   9'd0,   1'b0, 1'b0, 1'b0, 22'd0);
    send_fields(9'd70,  9'd0,   1'b0, 1'b0, 1'b0, 22'd0);
    send_fields(9'd10,  9'd0,   1'b0, 1'b0, 1'b0, 22'd1000);
    send_fields(9'd0,   9'd72,  1'b0, 1'b0, 1'b0, '1);
    send_fields(9'd75,  9'd75,  1'b0, 1'b0, 1'b0, 22'd5);
    send_fields(9'd71,  9'd0,   1'b0, 1'b0, 1'b1, 22'd5);
    send_fields(9'd70,  9'd0,   1'b0, 1'b0, 1'b0, 22'd5);
    send_fields(9'd66,  9'd0,   1'b0, 1'b0, 1'b0, 22'd5);
    send_fields(9'd63,  9'd0,   1'b0, 1'b0, 1'b0, 22'd5);
    send_fields(9'd80,  9'd0,   1'b0, 1'b0, 1'b0, 22'd7);
    send_fields(9'd511, 9'd0,   1'b0, 1'b0, 1'b1, 22'd7);
    send_fields(9'd0,   9'd151, 1'b0, 1'b0, 1'b0, 22'd7);
    send_fields(9'd5,   9'd150, 1'b0, 1'b0, 1'b0, 22'd7);
    send_fields(9'd511, 9'd60,  1'b1, 1'b0, 1'b0, 22'd9);
    send_fields(9'd3,   9'd511, 1'b0, 1'b1, 1'b0, 22'd9);
    send_fields(9'd2,   9'd100, 1'b0, 1'b0, 1'b1, 22'h2AAAAA);
    send_fields(9'h155, 9'h0AA, 1'b0, 1'b0, 1'b0, 22'h155555);
    send_fields(9'h0AA, 9'h155, 1'b0, 1'b0, 1'b0, 22'h2AAAAA);
    send_fields(9'd69,  9'd0,   1'b0, 1'b0, 1'b0, 22'h155555);
    send_fields(9'd0,   9'd0,   1'b0, 1'b0, 1'b0, 22'h2AAAAA);

    for (k = 0; k < N_PHASES; k++) begin
      drain();
      program_cfg(phase_cfg(k));
      if (k % 2 == 1) hold_req++;
      for (i = 0; i < BEATS_PER_PHASE; i++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 12));
        end
        send(rand_item());
        burst_left--;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (n_errors == 0 && n_pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
